// ----- rtl/core/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the triangle perimeter/area core.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset
`define TPA_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Check on every clock edge, reset included
`define TPA_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/tpa_pkg.sv -----
// ---------------------------------------------------------------------------
// tpa_pkg
// Widths, status codes and request types for the triangle perimeter/area core.
// ---------------------------------------------------------------------------
package tpa_pkg;

	localparam int SIDE_W      = 16;
	localparam int PER_W       = 18;
	localparam int PROD_W      = 2 * PER_W;
	localparam int HALF_W      = PROD_W / 2;
	localparam int Q_W         = 66;
	localparam int ROOT_W      = Q_W / 2;
	localparam int REM_W       = ROOT_W + 2;
	localparam int AREA_W      = ROOT_W - 2;
	localparam int S_TDATA_W   = 48;
	localparam int M_TDATA_W   = 56;
	localparam int M_TUSER_W   = 2;
	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_ZERO_SIDE = 2'd1,
		ST_NO_TRI    = 2'd2
	} status_t;

	// Classified request handed from the front part to the back part
	typedef struct packed {
		logic [PER_W-1:0] per;
		logic [PER_W-1:0] d_a;
		logic [PER_W-1:0] d_b;
		logic [PER_W-1:0] d_c;
		status_t          status;
		logic             equi;
	} item_t;

	// Side information carried along the arithmetic pipe
	typedef struct packed {
		logic [PER_W-1:0] per;
		status_t          status;
		logic             equi;
	} meta_t;

endpackage

// ----- rtl/core/triangle_perimeter_area.sv -----
// ---------------------------------------------------------------------------
// triangle_perimeter_area
// Perimeter, equilateral flag, status and Heron area of a stream of triangles.
// ---------------------------------------------------------------------------
// Usage:
//   Sides enter on the s_t* channel, one triangle per request, as three
//   unsigned Q12.4 values. Results leave on the m_t* channel, one per request
//   and in request order: perimeter Q14.4, area in 1/256 square inch, the
//   equilateral flag in tdata and the status code in tuser.
//   A request is accepted each cycle in which s_tvalid and s_tready are high;
//   with the result side ready the block takes one triangle every cycle.
//   From acceptance to the result on m_tdata a request passes the
//   classifying stage, which loads at the accepting edge, one queue slot,
//   three multiply stages and 33 square root stages (one root bit each), the
//   last of which is the result register.
//   When a result is held by a low m_tready the arithmetic pipe holds as a
//   whole; the queue of QUEUE_DEPTH entries and the classifying stage keep
//   taking requests until they fill, after which s_tready falls.
//   Reset empties all stages and the queue; no result is pending after it.
// ---------------------------------------------------------------------------
module triangle_perimeter_area
	import tpa_pkg::*;
#(
	parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // side_a, side_b, side_c
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,  // perimeter, area, is_equilateral, pad
	output logic [M_TUSER_W-1:0] m_tuser   // status
);

	localparam int PAD_W = M_TDATA_W - PER_W - AREA_W - 1;

	logic              fr_vld;
	logic              fr_rdy;
	item_t             fr_item;
	logic              q_vld;
	logic              q_rdy;
	item_t             q_item;
	logic [PER_W-1:0]  perimeter;
	logic [AREA_W-1:0] area;
	logic              is_equilateral;
	status_t           status;

	tpa_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (s_tvalid),
		.in_rdy   (s_tready),
		.side_a   (s_tdata[SIDE_W-1:0]),
		.side_b   (s_tdata[2*SIDE_W-1:SIDE_W]),
		.side_c   (s_tdata[3*SIDE_W-1:2*SIDE_W]),
		.out_vld  (fr_vld),
		.out_rdy  (fr_rdy),
		.out_item (fr_item)
	);

	tpa_queue #(
		.DEPTH (QUEUE_DEPTH_P)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_vld  (fr_vld),
		.push_rdy  (fr_rdy),
		.push_item (fr_item),
		.pop_vld   (q_vld),
		.pop_rdy   (q_rdy),
		.pop_item  (q_item)
	);

	tpa_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_vld     (q_vld),
		.in_rdy     (q_rdy),
		.in_item    (q_item),
		.out_vld    (m_tvalid),
		.out_rdy    (m_tready),
		.out_per    (perimeter),
		.out_area   (area),
		.out_equi   (is_equilateral),
		.out_status (status)
	);

	// Pack the result fields, lowest first
	assign m_tdata = {{PAD_W{1'b0}}, is_equilateral, area, perimeter};
	assign m_tuser = status;

endmodule

// ----- rtl/core/tpa_front.sv -----
// ---------------------------------------------------------------------------
// tpa_front
// Accepts a request, forms the perimeter and the Heron differences and
// classifies the triangle into one registered stage.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tpa_front
	import tpa_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_vld,
	output logic              in_rdy,
	input  logic [SIDE_W-1:0] side_a,
	input  logic [SIDE_W-1:0] side_b,
	input  logic [SIDE_W-1:0] side_c,
	output logic              out_vld,
	input  logic              out_rdy,
	output item_t             out_item
);

	logic             vld_s1;
	item_t            item_s1;
	item_t            item_nx;
	logic [PER_W-1:0] per;
	logic [PER_W-1:0] tw_a;
	logic [PER_W-1:0] tw_b;
	logic [PER_W-1:0] tw_c;
	logic             zero_side;
	logic             too_long;

	// Take a new request whenever the stage is empty or drains this cycle
	assign in_rdy   = !vld_s1 || out_rdy;
	assign out_vld  = vld_s1;
	assign out_item = item_s1;

	// Classify: zero side first, then triangle inequality
	always_comb begin
		per       = PER_W'(side_a) + PER_W'(side_b) + PER_W'(side_c);
		tw_a      = {1'b0, side_a, 1'b0};
		tw_b      = {1'b0, side_b, 1'b0};
		tw_c      = {1'b0, side_c, 1'b0};
		zero_side = (side_a == '0) || (side_b == '0) || (side_c == '0);
		too_long  = (tw_a > per) || (tw_b > per) || (tw_c > per);
		item_nx.per = per;
		item_nx.d_a = per - tw_a;
		item_nx.d_b = per - tw_b;
		item_nx.d_c = per - tw_c;
		if (zero_side) begin
			item_nx.status = ST_ZERO_SIDE;
		end else if (too_long) begin
			item_nx.status = ST_NO_TRI;
		end else begin
			item_nx.status = ST_OK;
		end
		item_nx.equi = !zero_side && !too_long && (side_a == side_b) && (side_a == side_c);
	end

	// Hold the stage valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_rdy) begin
			vld_s1 <= in_vld;
		end
	end

	// Load the classified request
	always_ff @(posedge clk) begin
		if (in_vld && in_rdy) begin
			item_s1 <= item_nx;
		end
	end

	`TPA_ASSERT(a_zero_side_class,
		(in_vld && in_rdy && side_a == '0) |=> (item_s1.status == ST_ZERO_SIDE),
		"front: zero side not classified")

	`TPA_ASSERT(a_equi_only_ok,
		(vld_s1 && item_s1.equi) |-> (item_s1.status == ST_OK),
		"front: equilateral flag on an error request")

endmodule

// ----- rtl/core/tpa_queue.sv -----
// ---------------------------------------------------------------------------
// tpa_queue
// Short first-in first-out queue that decouples the front and back parts.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tpa_queue
	import tpa_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_vld,
	output logic  push_rdy,
	input  item_t push_item,
	output logic  pop_vld,
	input  logic  pop_rdy,
	output item_t pop_item
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	item_t            mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_rdy = (count_q != CNT_W'(DEPTH));
	assign pop_vld  = (count_q != '0);
	assign push     = push_vld && push_rdy;
	assign pop      = pop_vld && pop_rdy;
	assign pop_item = mem_q[rd_ptr_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Store the pushed request
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	`TPA_ASSERT(a_count_up,
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1),
		"queue: occupancy did not rise on push")

	`TPA_ASSERT(a_count_down,
		(pop && !push) |=> (count_q == $past(count_q) - 1'b1),
		"queue: occupancy did not fall on pop")

endmodule

// ----- rtl/core/tpa_back.sv -----
// ---------------------------------------------------------------------------
// tpa_back
// Forms the Heron product over three multiply stages and takes its integer
// square root one bit per stage; the last stage is the result register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tpa_back
	import tpa_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_vld,
	output logic              in_rdy,
	input  item_t             in_item,
	output logic              out_vld,
	input  logic              out_rdy,
	output logic [PER_W-1:0]  out_per,
	output logic [AREA_W-1:0] out_area,
	output logic              out_equi,
	output status_t           out_status
);

	logic                adv;
	logic                vld_s1;
	logic                vld_s2;
	logic                vld_s3;
	logic [PROD_W-1:0]   x_s1;
	logic [PROD_W-1:0]   y_s1;
	meta_t               meta_s1;
	logic [PROD_W-1:0]   pp_hh_s2;
	logic [PROD_W-1:0]   pp_hl_s2;
	logic [PROD_W-1:0]   pp_lh_s2;
	logic [PROD_W-1:0]   pp_ll_s2;
	meta_t               meta_s2;
	logic [Q_W-1:0]      q_s3;
	meta_t               meta_s3;
	logic [2*PROD_W-1:0] q_sum;

	logic [Q_W-1:0]    rt_rad_s  [ROOT_W];
	logic [REM_W-1:0]  rt_rem_s  [ROOT_W];
	logic [ROOT_W-1:0] rt_root_s [ROOT_W];
	meta_t             rt_meta_s [ROOT_W];
	logic [ROOT_W-1:0] rt_vld_s;

	// The whole pipe moves unless the result register is held
	assign out_vld = rt_vld_s[ROOT_W-1];
	assign adv     = !out_vld || out_rdy;
	assign in_rdy  = adv;

	assign out_per    = rt_meta_s[ROOT_W-1].per;
	assign out_status = rt_meta_s[ROOT_W-1].status;
	assign out_equi   = rt_meta_s[ROOT_W-1].equi;
	assign out_area   = rt_root_s[ROOT_W-1][ROOT_W-1:2];

	// Recombine the partial products
	assign q_sum = {pp_hh_s2, {PROD_W{1'b0}}}
		+ {{HALF_W{1'b0}}, pp_hl_s2, {HALF_W{1'b0}}}
		+ {{HALF_W{1'b0}}, pp_lh_s2, {HALF_W{1'b0}}}
		+ {{PROD_W{1'b0}}, pp_ll_s2};

	// Hold valid flags of the multiply stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// Multiply stages: two factors, four partial products, one sum
	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1     <= in_item.per * in_item.d_a;
			y_s1     <= in_item.d_b * in_item.d_c;
			meta_s1  <= '{per: in_item.per, status: in_item.status, equi: in_item.equi};
			pp_hh_s2 <= x_s1[PROD_W-1:HALF_W] * y_s1[PROD_W-1:HALF_W];
			pp_hl_s2 <= x_s1[PROD_W-1:HALF_W] * y_s1[HALF_W-1:0];
			pp_lh_s2 <= x_s1[HALF_W-1:0] * y_s1[PROD_W-1:HALF_W];
			pp_ll_s2 <= x_s1[HALF_W-1:0] * y_s1[HALF_W-1:0];
			meta_s2  <= meta_s1;
			// Drop the product of an error request so its area comes out zero
			q_s3     <= (meta_s2.status == ST_OK) ? q_sum[Q_W-1:0] : '0;
			meta_s3  <= meta_s2;
		end
	end

	// Square root, one result bit per stage, most significant first
	for (genvar k = 0; k < ROOT_W; k++) begin : g_rt
		logic [Q_W-1:0]    rad_in;
		logic [REM_W-1:0]  rem_in;
		logic [ROOT_W-1:0] root_in;
		meta_t             meta_in;
		logic              vld_in;
		logic [REM_W-1:0]  rem_sh;
		logic [REM_W-1:0]  trial;
		logic [REM_W-1:0]  rem_nx;
		logic              ge;

		if (k == 0) begin : g_first
			assign rad_in  = q_s3;
			assign rem_in  = '0;
			assign root_in = '0;
			assign meta_in = meta_s3;
			assign vld_in  = vld_s3;
		end else begin : g_next
			assign rad_in  = rt_rad_s[k-1];
			assign rem_in  = rt_rem_s[k-1];
			assign root_in = rt_root_s[k-1];
			assign meta_in = rt_meta_s[k-1];
			assign vld_in  = rt_vld_s[k-1];
		end

		// Bring down two radicand bits and try the next root bit
		always_comb begin
			rem_sh = {rem_in[REM_W-3:0], rad_in[Q_W-1 -: 2]};
			trial  = {root_in, 2'b01};
			ge     = (rem_sh >= trial);
			rem_nx = ge ? rem_sh - trial : rem_sh;
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rt_rad_s[k]  <= rad_in << 2;
				rt_rem_s[k]  <= rem_nx;
				rt_root_s[k] <= {root_in[ROOT_W-2:0], ge};
				rt_meta_s[k] <= meta_in;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_vld_s[k] <= 1'b0;
			end else if (adv) begin
				rt_vld_s[k] <= vld_in;
			end
		end
	end

	`TPA_ASSERT_ALWAYS(a_error_area_zero,
		(out_vld && out_status != ST_OK) |-> (out_area == '0),
		"back: error result with non-zero area")

	`TPA_ASSERT(a_pipe_holds,
		(out_vld && !out_rdy) |=> (out_vld && out_area == $past(out_area)),
		"back: held result changed under stall")

endmodule
